>>> sv/pcq_pkg.sv
package pcq_pkg;

  localparam int TopDepth    = 64;
  localparam int MaxTopSizes = 4;
  localparam int ValW        = 24;
  localparam int TotalW      = 40;
  localparam int DetW        = 17;
  localparam int SizeW       = 7;
  localparam int AccW        = 30;
  localparam int NumW        = 53;
  localparam int QuoW        = 23;
  localparam int PctScale    = 100;

  localparam logic [2:0] RegDetLimit  = 3'd0;
  localparam logic [2:0] RegTopCount  = 3'd1;
  localparam logic [2:0] RegSizeA     = 3'd2;
  localparam logic [2:0] RegSizeB     = 3'd3;
  localparam logic [2:0] RegSizeC     = 3'd4;
  localparam logic [2:0] RegSizeD     = 3'd5;
  localparam logic [2:0] RegFracMode  = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_MUL,
    ST_DIV,
    ST_EMIT,
    ST_CLEAR
  } state_e;

  typedef struct packed {
    logic [23:0] count_value;
    logic        last_of_column;
  } item_t;

  typedef struct packed {
    logic [15:0] column_index;
    logic [39:0] column_total;
    logic [16:0] detected_count;
    logic [1:0]  top_slot;
    logic [22:0] top_share;
    logic        zero_total;
    logic        sizes_unsorted;
    logic        last_result;
  } result_t;

  typedef struct packed {
    logic            ins;
    logic            shift;
    logic            clr;
    logic [ValW-1:0] value;
  } cell_ctrl_t;

endpackage

>>> sv/pcq_cell.sv
module pcq_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pcq_pkg::cell_ctrl_t       ctrl_i,
  input  logic                      prev_lt_i,
  input  logic [pcq_pkg::ValW-1:0]  prev_val_i,
  input  logic [pcq_pkg::ValW-1:0]  next_val_i,
  output logic                      lt_o,
  output logic [pcq_pkg::ValW-1:0]  val_o
);
  import pcq_pkg::*;

  logic [ValW-1:0] val_q, val_d;

  // new word goes below any equal value already held
  assign lt_o = (val_q < ctrl_i.value);

  // clear, or take the word, the upper neighbour's value, or the lower one on drain
  always_comb begin
    val_d = val_q;
    if (ctrl_i.clr) begin
      val_d = '0;
    end else if (ctrl_i.shift) begin
      val_d = next_val_i;
    end else if (ctrl_i.ins && lt_o) begin
      val_d = prev_lt_i ? prev_val_i : ctrl_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;

endmodule

>>> sv/pcq_div.sv
module pcq_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [pcq_pkg::NumW-1:0]    num_i,
  input  logic [pcq_pkg::TotalW-1:0]  den_i,
  output logic                        done_o,
  output logic [pcq_pkg::QuoW-1:0]    quo_o
);
  import pcq_pkg::*;

  logic [TotalW-1:0] rem_q, rem_d;
  logic [QuoW-1:0]   nsh_q, nsh_d;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic [4:0]        cnt_q, cnt_d;
  logic              run_q, run_d;
  logic [TotalW:0]   trial;

  assign trial = {rem_q, nsh_q[QuoW-1]};

  // one quotient bit per cycle, restoring
  always_comb begin
    rem_d = rem_q;
    nsh_d = nsh_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    run_d = run_q;
    if (go_i) begin
      rem_d = TotalW'(num_i[NumW-1:QuoW]);
      nsh_d = num_i[QuoW-1:0];
      quo_d = '0;
      cnt_d = 5'(QuoW);
      run_d = 1'b1;
    end else if (run_q) begin
      nsh_d = {nsh_q[QuoW-2:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        rem_d = TotalW'(trial - {1'b0, den_i});
        quo_d = {quo_q[QuoW-2:0], 1'b1};
      end else begin
        rem_d = trial[TotalW-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) run_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      run_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nsh_q <= nsh_d;
    quo_q <= quo_d;
  end

  assign done_o = run_q && (cnt_q == 5'd1);
  assign quo_o  = quo_d;

endmodule

>>> sv/per_column_count_qc_topk.sv
// Channel   Ports                           Word
// input     start, busy, item_i             count_value, last_of_column
// config    cfg_we_i, cfg_idx_i, cfg_data_i one register write
// result    res_valid_o, res_o              one share per top size
//
// A count that is not last is taken while busy is low: it is inserted into the
// 64-cell sorted chain the same cycle. After the last count busy stays high
// while the chain drains one cell a cycle into the top sum and each slot
// runs a serial divide. Reset clears the chain at once.
// Results appear for one cycle each.
module per_column_count_qc_topk (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  pcq_pkg::item_t   item_i,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [23:0]      cfg_data_i,
  output logic             res_valid_o,
  output pcq_pkg::result_t res_o
);
  import pcq_pkg::*;

  state_e state_q, state_d;

  logic [ValW-1:0]   det_limit_q;
  logic [2:0]        top_count_q;
  logic [SizeW-1:0]  size_q [MaxTopSizes];
  logic              frac_q;

  logic [TotalW-1:0] total_q, total_d;
  logic [DetW-1:0]   det_q, det_d;
  logic [15:0]       col_q;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [SizeW-1:0]  x_q, x_d;
  logic [SizeW-1:0]  pmax_q, pmax_d;
  logic [1:0]        slot_q, slot_d;
  logic              res_valid_q;
  result_t           res_q;

  logic              accept;
  logic [2:0]        ntop;
  logic              unsorted;
  logic [SizeW-1:0]  want, target;
  logic [TotalW:0]   total_sum;
  logic [NumW-1:0]   num;
  logic              div_go, div_done;
  logic [QuoW-1:0]   quo;
  logic              last_slot;

  cell_ctrl_t        ctrl;
  logic [ValW-1:0]   val [TopDepth];
  logic              lt  [TopDepth];

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);
  assign ntop   = (top_count_q > 3'(MaxTopSizes)) ? 3'(MaxTopSizes) : top_count_q;
  assign last_slot = ({1'b0, slot_q} + 3'd1 == ntop);

  // flag a slot in use whose size falls below the one before
  always_comb begin
    unsorted = 1'b0;
    for (int i = 1; i < MaxTopSizes; i++) begin
      if (3'(i) < ntop && size_q[i] < size_q[i-1]) unsorted = 1'b1;
    end
  end

  // prefix length never shrinks and stops at the chain depth
  assign want   = (size_q[slot_q] > pmax_q) ? size_q[slot_q] : pmax_q;
  assign target = (want > SizeW'(TopDepth)) ? SizeW'(TopDepth) : want;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_limit_q <= '0;
      top_count_q <= '0;
      frac_q      <= 1'b0;
      for (int i = 0; i < MaxTopSizes; i++) size_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegDetLimit: det_limit_q <= cfg_data_i;
        RegTopCount: top_count_q <= cfg_data_i[2:0];
        RegSizeA:    size_q[0]   <= cfg_data_i[SizeW-1:0];
        RegSizeB:    size_q[1]   <= cfg_data_i[SizeW-1:0];
        RegSizeC:    size_q[2]   <= cfg_data_i[SizeW-1:0];
        RegSizeD:    size_q[3]   <= cfg_data_i[SizeW-1:0];
        RegFracMode: frac_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // cell chain
  always_comb begin
    ctrl.ins   = accept;
    ctrl.shift = (state_q == ST_DRAIN) && (x_q < target);
    ctrl.clr   = (state_q == ST_CLEAR);
    ctrl.value = item_i.count_value;
  end

  for (genvar g = 0; g < TopDepth; g++) begin : g_cell
    logic            p_lt;
    logic [ValW-1:0] p_val, n_val;
    if (g == 0) begin : g_head
      assign p_lt  = 1'b0;
      assign p_val = '0;
    end else begin : g_body
      assign p_lt  = lt[g-1];
      assign p_val = val[g-1];
    end
    if (g == TopDepth - 1) begin : g_tail
      assign n_val = '0;
    end else begin : g_mid
      assign n_val = val[g+1];
    end
    pcq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .prev_lt_i  (p_lt),
      .prev_val_i (p_val),
      .next_val_i (n_val),
      .lt_o       (lt[g]),
      .val_o      (val[g])
    );
  end

  // scale the top sum; divider registers it
  assign num    = frac_q ? {7'd0, acc_q, 16'd0}
                         : ({7'd0, acc_q, 16'd0} * NumW'(PctScale));
  assign div_go = (state_q == ST_MUL);

  pcq_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .num_i  (num),
    .den_i  (total_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && item_i.last_of_column) begin
                  state_d = (ntop == 3'd0) ? ST_CLEAR : ST_DRAIN;
                end
      ST_DRAIN: if (x_q >= target) state_d = ST_MUL;
      ST_MUL:   state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_EMIT;
      ST_EMIT:  state_d = last_slot ? ST_CLEAR : ST_DRAIN;
      ST_CLEAR: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // running sums, drain counter and slot
  always_comb begin
    total_sum = {1'b0, total_q} + (TotalW+1)'(item_i.count_value);
    total_d   = total_q;
    det_d     = det_q;
    acc_d     = acc_q;
    x_d       = x_q;
    pmax_d    = pmax_q;
    slot_d    = slot_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          total_d = total_sum[TotalW] ? '1 : total_sum[TotalW-1:0];
          if (item_i.count_value > det_limit_q && det_q != '1) det_d = det_q + DetW'(1);
        end
        acc_d  = '0;
        x_d    = '0;
        pmax_d = '0;
        slot_d = '0;
      end
      ST_DRAIN: begin
        if (x_q < target) begin
          acc_d = acc_q + AccW'(val[0]);
          x_d   = x_q + SizeW'(1);
        end else begin
          pmax_d = target;
        end
      end
      ST_EMIT: slot_d = slot_q + 2'd1;
      ST_CLEAR: begin
        total_d = '0;
        det_d   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      det_q       <= '0;
      col_q       <= '0;
      acc_q       <= '0;
      x_q         <= '0;
      pmax_q      <= '0;
      slot_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      det_q       <= det_d;
      acc_q       <= acc_d;
      x_q         <= x_d;
      pmax_q      <= pmax_d;
      slot_q      <= slot_d;
      res_valid_q <= (state_q == ST_EMIT);
      if (state_q == ST_CLEAR) col_q <= col_q + 16'd1;
    end
  end

  // hold the result word for its one cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT) begin
      res_q.column_index   <= col_q;
      res_q.column_total   <= total_q;
      res_q.detected_count <= det_q;
      res_q.top_slot       <= slot_q;
      res_q.top_share      <= (total_q == '0) ? '0 : quo;
      res_q.zero_total     <= (total_q == '0);
      res_q.sizes_unsorted <= unsorted;
      res_q.last_result    <= last_slot;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
